>>> rtl/afl_pkg.sv
// shared types, constants and codes for the letterbox scaler
package afl_pkg;

    localparam int FRAME_PIXELS = 65536;
    localparam int MAX_DIM      = 4096;
    localparam int FRAME_AW     = 16;
    localparam int DIM_W        = 13;
    localparam int COORD_W      = 12;
    localparam int PROD_W       = 2 * DIM_W;
    localparam int NUM_W        = COORD_W + DIM_W;
    localparam int CFG_AW       = 3;
    localparam int CFG_DW       = 13;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_AW-1:0] REG_SRC_PITCH  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_DST_WIDTH  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_DST_HEIGHT = 3'd4;
    localparam logic [CFG_AW-1:0] REG_PIX_FORMAT = 3'd5;

    // pixel formats
    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_BGRA = 2'd1;

    // opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_CFG  = 2'd1;
    localparam logic [1:0] STAT_OUTSIDE  = 2'd2;

    localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;

    typedef struct packed {
        logic               opcode;
        logic [15:0]        frame_index;
        logic [31:0]        pixel_in;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
    } in_t;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic [1:0]  status;
    } out_t;

    // settings and derived fit geometry handed to the pixel pipeline
    typedef struct packed {
        logic             busy;
        logic             ok;
        logic [DIM_W-1:0] src_width;
        logic [DIM_W-1:0] src_height;
        logic [DIM_W-1:0] src_pitch;
        logic [DIM_W-1:0] dst_width;
        logic [DIM_W-1:0] dst_height;
        logic [1:0]       pix_format;
        logic [DIM_W-1:0] fit_w;
        logic [DIM_W-1:0] fit_h;
        logic [DIM_W-1:0] off_x;
        logic [DIM_W-1:0] off_y;
    } afl_cfg_t;

    typedef struct packed {
        logic               valid;
        logic               op;
        logic [FRAME_AW-1:0] fidx;
        logic [31:0]        pix;
        logic [1:0]         status;
        logic               border;
        logic [NUM_W-1:0]   rx;
        logic [NUM_W-1:0]   ry;
        logic [COORD_W-1:0] qx;
        logic [COORD_W-1:0] qy;
    } pipe_t;

endpackage

>>> rtl/aspect_fit_letterbox_scaler.sv
// top level: pipelined letterbox scaler with source frame memory
// Takes one request per clock unless the output stalls or the fit geometry is
// being recomputed; a read returns a result, write requests give no result.
// A read passes the 12-stage pipelined divider that maps target to source
// coordinates, the index multiply and the registered frame memory read.
// After any configuration write the fit geometry is recomputed by a single
// sequential divider, whose division is skipped when the settings are invalid,
// while s_ready is low.
module aspect_fit_letterbox_scaler (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  afl_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output afl_pkg::out_t               m_data,
    input  logic                        cfg_we,
    input  logic [afl_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [afl_pkg::CFG_DW-1:0]  cfg_wdata
);
    import afl_pkg::*;

    localparam int DIV_STEPS = COORD_W;
    localparam int N_ST      = DIV_STEPS + 4;

    afl_cfg_t cfg;
    pipe_t    st_reg  [N_ST];
    pipe_t    st_next [N_ST];
    logic     adv;
    logic     m_valid_reg, m_valid_next;
    out_t     m_data_reg, m_data_next;
    logic [31:0] frame_mem [FRAME_PIXELS];
    logic [31:0] rd_reg;
    logic [31:0] pix_sel;
    logic [DIM_W-1:0] x_ext, y_ext;
    logic [DIM_W:0]   x_end, y_end;
    logic [NUM_W-1:0] trial_x, trial_y;

    afl_cfg_unit u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .cfg      (cfg)
    );

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && !cfg.busy;
    assign x_ext   = DIM_W'(s_data.target_x);
    assign y_ext   = DIM_W'(s_data.target_y);
    assign x_end   = (DIM_W+1)'(cfg.off_x) + (DIM_W+1)'(cfg.fit_w);
    assign y_end   = (DIM_W+1)'(cfg.off_y) + (DIM_W+1)'(cfg.fit_h);

    always_comb begin
        trial_x = '0;
        trial_y = '0;
        // entry stage: classify and offset
        st_next[0]        = '0;
        st_next[0].valid  = s_valid && s_ready;
        st_next[0].op     = s_data.opcode;
        st_next[0].fidx   = s_data.frame_index;
        st_next[0].pix    = s_data.pixel_in;
        if (!cfg.ok) begin
            st_next[0].status = STAT_BAD_CFG;
        end else if (x_ext >= cfg.dst_width || y_ext >= cfg.dst_height) begin
            st_next[0].status = STAT_OUTSIDE;
        end else begin
            st_next[0].status = STAT_OK;
        end
        st_next[0].border = (x_ext < cfg.off_x) || ((DIM_W+1)'(x_ext) >= x_end)
                         || (y_ext < cfg.off_y) || ((DIM_W+1)'(y_ext) >= y_end);
        st_next[0].rx = NUM_W'(x_ext - cfg.off_x);
        st_next[0].ry = NUM_W'(y_ext - cfg.off_y);

        // scale by source size
        st_next[1]    = st_reg[0];
        st_next[1].rx = NUM_W'(st_reg[0].rx[COORD_W-1:0]) * NUM_W'(cfg.src_width);
        st_next[1].ry = NUM_W'(st_reg[0].ry[COORD_W-1:0]) * NUM_W'(cfg.src_height);
        st_next[1].qx = '0;
        st_next[1].qy = '0;

        // one quotient bit per stage, msb first
        for (int j = 1; j <= DIV_STEPS; j++) begin
            st_next[j+1] = st_reg[j];
            trial_x = NUM_W'(cfg.fit_w) << (DIV_STEPS - j);
            trial_y = NUM_W'(cfg.fit_h) << (DIV_STEPS - j);
            if (st_reg[j].rx >= trial_x) begin
                st_next[j+1].rx = st_reg[j].rx - trial_x;
                st_next[j+1].qx[DIV_STEPS-j] = 1'b1;
            end
            if (st_reg[j].ry >= trial_y) begin
                st_next[j+1].ry = st_reg[j].ry - trial_y;
                st_next[j+1].qy[DIV_STEPS-j] = 1'b1;
            end
        end

        // source index for reads
        st_next[N_ST-2] = st_reg[N_ST-3];
        if (st_reg[N_ST-3].op == OP_READ) begin
            st_next[N_ST-2].fidx = FRAME_AW'(
                PROD_W'(st_reg[N_ST-3].qy) * PROD_W'(cfg.src_pitch)
                + PROD_W'(st_reg[N_ST-3].qx));
        end

        // memory access stage
        st_next[N_ST-1] = st_reg[N_ST-2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N_ST; i++) begin
                st_reg[i] <= '0;
            end
        end else if (adv) begin
            for (int i = 0; i < N_ST; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // writes and reads share one port in request order
    always_ff @(posedge aclk) begin
        if (adv && st_reg[N_ST-2].valid) begin
            if (st_reg[N_ST-2].op == OP_WRITE) begin
                frame_mem[st_reg[N_ST-2].fidx] <= st_reg[N_ST-2].pix;
            end else begin
                rd_reg <= frame_mem[st_reg[N_ST-2].fidx];
            end
        end
    end

    always_comb begin
        pix_sel = rd_reg;
        if (cfg.pix_format == FMT_BGRA) begin
            pix_sel = {rd_reg[31:24], rd_reg[7:0], rd_reg[15:8], rd_reg[23:16]};
        end
        m_valid_next = st_reg[N_ST-1].valid && (st_reg[N_ST-1].op == OP_READ);
        m_data_next.status = st_reg[N_ST-1].status;
        if (st_reg[N_ST-1].status != STAT_OK) begin
            m_data_next.pixel_out = '0;
        end else if (st_reg[N_ST-1].border) begin
            m_data_next.pixel_out = OPAQUE_BLACK;
        end else begin
            m_data_next.pixel_out = pix_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/afl_cfg_unit.sv
// configuration registers and sequential fit-size computation
module afl_cfg_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [afl_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [afl_pkg::CFG_DW-1:0]   cfg_wdata,
    output afl_pkg::afl_cfg_t            cfg
);
    import afl_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PROD = 3'd1;
    localparam logic [2:0] ST_SEL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [DIM_W-1:0]  src_w_reg, src_h_reg, pitch_reg, dst_w_reg, dst_h_reg;
    logic [1:0]        fmt_reg;
    logic [2:0]        state_reg, state_next;
    logic [PROD_W-1:0] prod_a_reg, prod_b_reg;
    logic              valid_reg, wide_reg, ok_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [DIM_W-1:0]  den_reg, q_reg;
    logic [3:0]        cnt_reg;
    logic [DIM_W-1:0]  fit_w_reg, fit_h_reg, off_x_reg, off_y_reg;
    logic [3:0]        bit_k;
    logic [PROD_W-1:0] trial;
    logic [DIM_W-1:0]  fit_q, fit_w_new, fit_h_new;
    logic              settings_ok;
    logic [PROD_W-1:0] pitch_prod;

    assign bit_k = cnt_reg - 4'd1;
    assign trial = PROD_W'(den_reg) << bit_k;
    assign fit_q = (q_reg == '0) ? DIM_W'(1) : q_reg;
    assign fit_w_new = wide_reg ? dst_w_reg : fit_q;
    assign fit_h_new = wide_reg ? fit_q : dst_h_reg;
    assign pitch_prod = PROD_W'(pitch_reg) * PROD_W'(src_h_reg);

    assign settings_ok = (fmt_reg != FMT_NONE)
        && (src_w_reg != '0) && (src_h_reg != '0)
        && (dst_w_reg != '0) && (dst_h_reg != '0)
        && (src_w_reg <= DIM_W'(MAX_DIM)) && (src_h_reg <= DIM_W'(MAX_DIM))
        && (dst_w_reg <= DIM_W'(MAX_DIM)) && (dst_h_reg <= DIM_W'(MAX_DIM))
        && (pitch_reg >= src_w_reg)
        && (pitch_prod <= PROD_W'(FRAME_PIXELS));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: state_next = ST_IDLE;
            ST_PROD: state_next = ST_SEL;
            ST_SEL:  state_next = valid_reg ? ST_DIV : ST_IDLE;
            ST_DIV:  state_next = (cnt_reg == 4'd1) ? ST_FIN : ST_DIV;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        // any write restarts the derivation
        if (cfg_we) begin
            state_next = ST_PROD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= '0;
            src_h_reg <= '0;
            pitch_reg <= '0;
            dst_w_reg <= '0;
            dst_h_reg <= '0;
            fmt_reg   <= '0;
            state_reg <= ST_IDLE;
            ok_reg    <= 1'b0;
            valid_reg <= 1'b0;
            wide_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                ok_reg <= 1'b0;
                unique case (cfg_addr)
                    REG_SRC_WIDTH:  src_w_reg <= cfg_wdata[DIM_W-1:0];
                    REG_SRC_HEIGHT: src_h_reg <= cfg_wdata[DIM_W-1:0];
                    REG_SRC_PITCH:  pitch_reg <= cfg_wdata[DIM_W-1:0];
                    REG_DST_WIDTH:  dst_w_reg <= cfg_wdata[DIM_W-1:0];
                    REG_DST_HEIGHT: dst_h_reg <= cfg_wdata[DIM_W-1:0];
                    REG_PIX_FORMAT: fmt_reg   <= cfg_wdata[1:0];
                    default: ;
                endcase
            end else begin
                unique case (state_reg)
                    ST_PROD: begin
                        valid_reg <= settings_ok;
                        wide_reg  <= 1'b0;
                    end
                    ST_SEL: begin
                        wide_reg <= prod_a_reg > prod_b_reg;
                        cnt_reg  <= 4'(DIM_W);
                    end
                    ST_DIV: cnt_reg <= cnt_reg - 4'd1;
                    ST_FIN: ok_reg <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_PROD: begin
                prod_a_reg <= PROD_W'(src_w_reg) * PROD_W'(dst_h_reg);
                prod_b_reg <= PROD_W'(dst_w_reg) * PROD_W'(src_h_reg);
            end
            ST_SEL: begin
                q_reg <= '0;
                if (prod_a_reg > prod_b_reg) begin
                    rem_reg <= prod_b_reg;
                    den_reg <= src_w_reg;
                end else begin
                    rem_reg <= prod_a_reg;
                    den_reg <= src_h_reg;
                end
            end
            ST_DIV: begin
                if (rem_reg >= trial) begin
                    rem_reg <= rem_reg - trial;
                    q_reg   <= q_reg | (DIM_W'(1) << bit_k);
                end
            end
            ST_FIN: begin
                fit_w_reg <= fit_w_new;
                fit_h_reg <= fit_h_new;
                off_x_reg <= (dst_w_reg - fit_w_new) >> 1;
                off_y_reg <= (dst_h_reg - fit_h_new) >> 1;
            end
            default: ;
        endcase
    end

    always_comb begin
        cfg.busy       = (state_reg != ST_IDLE);
        cfg.ok         = ok_reg;
        cfg.src_width  = src_w_reg;
        cfg.src_height = src_h_reg;
        cfg.src_pitch  = pitch_reg;
        cfg.dst_width  = dst_w_reg;
        cfg.dst_height = dst_h_reg;
        cfg.pix_format = fmt_reg;
        cfg.fit_w      = fit_w_reg;
        cfg.fit_h      = fit_h_reg;
        cfg.off_x      = off_x_reg;
        cfg.off_y      = off_y_reg;
    end

endmodule
